FILE: rtl/core/ggpc_pkg.sv
package ggpc_pkg;

    // field widths
    localparam int unsigned POS_W  = 12;
    localparam int unsigned HD_W   = 11;
    localparam int unsigned THR_W  = 8;
    localparam int unsigned TURN_W = 14;
    localparam int unsigned SPD_W  = 12;

    // stream word widths
    localparam int unsigned IN_W  = 40;
    localparam int unsigned OUT_W = 32;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 12;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_X    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_Y    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ARRIVE_TH = 2'd2;

    // datapath widths
    localparam int unsigned DIF_W  = POS_W + 1;        // goal - pose
    localparam int unsigned CRD_W  = 24;               // cordic x and y, offset scaled by 256
    localparam int unsigned ANG_W  = 20;               // angle, Q.16 radians
    localparam int unsigned SQ_W   = 2 * POS_W;        // one squared offset
    localparam int unsigned N_W    = SQ_W + 1;         // sum of squares
    localparam int unsigned RT_W   = N_W + 1;          // root and remainder in the sqrt
    localparam int unsigned THS_W  = 2 * THR_W;        // squared threshold
    localparam int unsigned B_W    = ANG_W + 1 - 8;    // bearing, Q.8
    localparam int unsigned DIFF_W = B_W + 1;          // bearing - heading
    localparam int unsigned T4_W   = DIFF_W + 2;       // times four
    localparam int unsigned RTQ_W  = 14;               // useful bits of the rounded root

    localparam int unsigned CRD_ITER  = 16;
    localparam int unsigned SQRT_ITER = (N_W + 1) / 2;

    localparam logic signed [ANG_W-1:0]  PI_Q16      = 20'sd205887;
    localparam logic signed [ANG_W:0]    ROUND_Q8    = 21'sd128;
    localparam logic signed [T4_W-1:0]   TURN_LIM    = 16'sd6434;
    localparam logic        [RTQ_W-2:0]  SPEED_LIM   = 13'd2897;
    localparam logic        [THR_W-1:0]  THR_RESET   = 8'd26;
    localparam logic        [THS_W-1:0]  THR_SQ_RESET = THS_W'(THR_RESET) * THS_W'(THR_RESET);

    typedef struct packed {
        logic        [POS_W-1:0] pose_x;
        logic        [POS_W-1:0] pose_y;
        logic signed [HD_W-1:0]  heading;
    } t_pose;

    typedef struct packed {
        logic [POS_W-1:0] goal_x;
        logic [POS_W-1:0] goal_y;
        logic [THS_W-1:0] thr_sq;
    } t_cfg;

    typedef struct packed {
        logic signed [CRD_W-1:0] x;
        logic signed [CRD_W-1:0] y;
        logic signed [ANG_W-1:0] z;
        logic                    zero;
        logic signed [HD_W-1:0]  hd;
        logic        [SQ_W-1:0]  sqx;
        logic        [SQ_W-1:0]  sqy;
        logic        [RT_W-1:0]  rem;
        logic        [RT_W-1:0]  root;
        logic                    arrived;
    } t_stage;

    typedef struct packed {
        logic signed [TURN_W-1:0] turn_rate;
        logic        [SPD_W-1:0]  forward_speed;
        logic                     arrived;
    } t_result;

    function automatic logic signed [ANG_W-1:0] atan_q16(input int unsigned i);
        logic signed [ANG_W-1:0] a;
        case (i)
            0:       a = 20'sd51472;
            1:       a = 20'sd30386;
            2:       a = 20'sd16055;
            3:       a = 20'sd8150;
            4:       a = 20'sd4091;
            5:       a = 20'sd2047;
            6:       a = 20'sd1024;
            7:       a = 20'sd512;
            8:       a = 20'sd256;
            9:       a = 20'sd128;
            10:      a = 20'sd64;
            11:      a = 20'sd32;
            12:      a = 20'sd16;
            13:      a = 20'sd8;
            14:      a = 20'sd4;
            15:      a = 20'sd2;
            default: a = '0;
        endcase
        return a;
    endfunction

    // stage k (1..CRD_ITER): one cordic rotation, plus one sqrt step where it falls (setup, digit or rounding)
    function automatic t_stage stage_step(input t_stage s, input int unsigned k,
                                          input logic [THS_W-1:0] thr_sq);
        t_stage                  o;
        logic signed [CRD_W-1:0] xs;
        logic signed [CRD_W-1:0] ys;
        logic        [N_W-1:0]   n;
        logic        [RT_W-1:0]  bitv;
        logic        [RT_W-1:0]  trial;
        o  = s;
        xs = $signed(s.x) >>> (k - 1);
        ys = $signed(s.y) >>> (k - 1);
        n     = '0;
        bitv  = '0;
        trial = '0;
        if (!s.y[CRD_W-1]) begin
            o.x = s.x + ys;
            o.y = s.y - xs;
            o.z = s.z + atan_q16(k - 1);
        end else begin
            o.x = s.x - ys;
            o.y = s.y + xs;
            o.z = s.z - atan_q16(k - 1);
        end
        if (k == 1) begin
            n         = N_W'(s.sqx) + N_W'(s.sqy);
            o.rem     = RT_W'(n);
            o.root    = '0;
            o.arrived = (n < N_W'(thr_sq));
        end else if (k <= SQRT_ITER + 1) begin
            bitv  = RT_W'(1) << (2 * (SQRT_ITER + 1 - k));
            trial = s.root + bitv;
            if (s.rem >= trial) begin
                o.rem  = s.rem - trial;
                o.root = (s.root >> 1) + bitv;
            end else begin
                o.root = s.root >> 1;
            end
        end else if (k == SQRT_ITER + 2) begin
            // round to nearest
            if (s.rem > s.root) begin
                o.root = s.root + RT_W'(1);
            end
        end
        return o;
    endfunction

endpackage

FILE: rtl/core/ggpc_pipe.sv
module ggpc_pipe
    import ggpc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  logic    i_vld,
    input  t_pose   i_pose,
    input  t_cfg    i_cfg,
    output logic    o_vld,
    output t_result o_res
);

    t_stage  r_st  [0:CRD_ITER];
    logic    r_vld [0:CRD_ITER];
    t_result r_res;
    logic    r_res_vld;

    t_stage  n_st0;
    t_result n_res;

    logic signed [DIF_W-1:0]   dx;
    logic signed [DIF_W-1:0]   dy;
    logic signed [2*DIF_W-1:0] pxx;
    logic signed [2*DIF_W-1:0] pyy;
    logic signed [CRD_W-1:0]   x0;
    logic signed [CRD_W-1:0]   y0;

    // front: offsets, squares and the half-turn for the left half plane
    always_comb begin
        dx  = $signed({1'b0, i_cfg.goal_x}) - $signed({1'b0, i_pose.pose_x});
        dy  = $signed({1'b0, i_cfg.goal_y}) - $signed({1'b0, i_pose.pose_y});
        pxx = dx * dx;
        pyy = dy * dy;
        x0  = {{(CRD_W-DIF_W-8){dx[DIF_W-1]}}, dx, 8'h00};
        y0  = {{(CRD_W-DIF_W-8){dy[DIF_W-1]}}, dy, 8'h00};
        n_st0         = '0;
        n_st0.zero    = (dx == '0) && (dy == '0);
        n_st0.hd      = i_pose.heading;
        n_st0.sqx     = pxx[SQ_W-1:0];
        n_st0.sqy     = pyy[SQ_W-1:0];
        if (dx[DIF_W-1]) begin
            n_st0.x = -x0;
            n_st0.y = -y0;
            n_st0.z = dy[DIF_W-1] ? -PI_Q16 : PI_Q16;
        end else begin
            n_st0.x = x0;
            n_st0.y = y0;
            n_st0.z = '0;
        end
    end

    logic signed [ANG_W:0]    zr;
    logic signed [B_W-1:0]    b;
    logic signed [DIFF_W-1:0] diff;
    logic signed [T4_W-1:0]   t4;
    logic        [RTQ_W-1:0]  rp1;
    logic        [RTQ_W-2:0]  spd;

    // back: round the angle to Q.8, subtract the heading, scale, saturate; round and halve the root into the speed
    always_comb begin
        zr   = $signed({r_st[CRD_ITER].z[ANG_W-1], r_st[CRD_ITER].z}) + ROUND_Q8;
        b    = r_st[CRD_ITER].zero ? '0 : zr[ANG_W:8];
        diff = {b[B_W-1], b}
             - {{(DIFF_W-HD_W){r_st[CRD_ITER].hd[HD_W-1]}}, r_st[CRD_ITER].hd};
        t4   = {diff, 2'b00};
        rp1  = r_st[CRD_ITER].root[RTQ_W-1:0] + RTQ_W'(1);
        spd  = rp1[RTQ_W-1:1];
        if (t4 > TURN_LIM) begin
            n_res.turn_rate = TURN_LIM[TURN_W-1:0];
        end else if (t4 < -TURN_LIM) begin
            n_res.turn_rate = TURN_W'(-TURN_LIM);
        end else begin
            n_res.turn_rate = t4[TURN_W-1:0];
        end
        n_res.forward_speed = (spd > SPEED_LIM) ? SPEED_LIM[SPD_W-1:0] : spd[SPD_W-1:0];
        n_res.arrived       = r_st[CRD_ITER].arrived;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= CRD_ITER; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_res_vld <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            for (int k = 1; k <= CRD_ITER; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            r_res_vld <= r_vld[CRD_ITER];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0] <= n_st0;
            for (int k = 1; k <= CRD_ITER; k++) begin
                r_st[k] <= stage_step(r_st[k-1], k, i_cfg.thr_sq);
            end
            r_res <= n_res;
        end
    end

    assign o_vld = r_res_vld;
    assign o_res = r_res;

endmodule

FILE: rtl/core/go_to_goal_p_controller_unit.sv
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   pose_x, pose_y, heading
// m_axis    out  m_axis_tvalid/m_axis_tready   turn_rate, forward_speed, arrived
// cfg       in   i_cfg_valid/o_cfg_ready       i_cfg_index, i_cfg_data
//
// one word accepted per cycle while s_axis_tready is high; a taken word passes the front stage,
// 16 cordic stages carrying the sqrt digits and the output register
// reset clears the stage valid bits, the skid valid flag and the goal registers
// a stalled output parks one result in the skid register; input ready drops
// only while that register is full, and the whole pipeline then holds
module go_to_goal_p_controller_unit
    import ggpc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_W-1:0]       s_axis_tdata,   // pose_x[11:0], pose_y[23:12], heading[34:24]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_W-1:0]      m_axis_tdata,   // turn_rate[13:0], forward_speed[25:14],
                                                  // arrived[26]
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [POS_W-1:0] r_goal_x;
    logic [POS_W-1:0] r_goal_y;
    logic [THR_W-1:0] r_thr;
    logic [THS_W-1:0] r_thr_sq;

    t_result r_skid;
    logic    r_skid_vld;

    logic    en;
    t_pose   pose;
    t_cfg    cfg;
    logic    pipe_vld;
    t_result pipe_res;
    t_result res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal_x <= '0;
            r_goal_y <= '0;
            r_thr    <= THR_RESET;
            r_thr_sq <= THR_SQ_RESET;
        end else begin
            r_thr_sq <= THS_W'(r_thr) * THS_W'(r_thr);
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_GOAL_X:    r_goal_x <= i_cfg_data[POS_W-1:0];
                    CFG_GOAL_Y:    r_goal_y <= i_cfg_data[POS_W-1:0];
                    CFG_ARRIVE_TH: r_thr    <= i_cfg_data[THR_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign pose.pose_x  = s_axis_tdata[POS_W-1:0];
    assign pose.pose_y  = s_axis_tdata[2*POS_W-1:POS_W];
    assign pose.heading = $signed(s_axis_tdata[2*POS_W+HD_W-1:2*POS_W]);

    assign cfg.goal_x = r_goal_x;
    assign cfg.goal_y = r_goal_y;
    assign cfg.thr_sq = r_thr_sq;

    assign en            = !r_skid_vld;
    assign s_axis_tready = en;

    ggpc_pipe u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (s_axis_tvalid),
        .i_pose  (pose),
        .i_cfg   (cfg),
        .o_vld   (pipe_vld),
        .o_res   (pipe_res)
    );

    // catch the result that would be pushed out while the sink stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (m_axis_tready) begin
                r_skid_vld <= 1'b0;
            end
        end else if (pipe_vld && !m_axis_tready) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_vld && pipe_vld && !m_axis_tready) begin
            r_skid <= pipe_res;
        end
    end

    assign res           = r_skid_vld ? r_skid : pipe_res;
    assign m_axis_tvalid = r_skid_vld || pipe_vld;
    assign m_axis_tdata  = {{(OUT_W-TURN_W-SPD_W-1){1'b0}},
                            res.arrived, res.forward_speed, res.turn_rate};

endmodule
